FILE: design/terr_pkg.sv
// Shared types and constants for the timed event record/replay block.
// No dependencies; used by terr_ctrl and timed_event_record_replay.
package terr_pkg;

  localparam int ENTRY_W = 35;
  localparam logic [15:0] MOUSE_MIN_RST = 16'd30;

  typedef enum logic [3:0] {
    ACT_TICK       = 4'd0,
    ACT_START_REC  = 4'd1,
    ACT_STOP_REC   = 4'd2,
    ACT_PLAY       = 4'd3,
    ACT_PLAY_FAST  = 4'd4,
    ACT_STOP_PLAY  = 4'd5,
    ACT_KEY_DOWN   = 4'd6,
    ACT_KEY_UP     = 4'd7,
    ACT_ENCODER    = 4'd8,
    ACT_MOUSE      = 4'd9
  } action_t;

  typedef enum logic [2:0] {
    ET_KEY_DOWN = 3'd0,
    ET_KEY_UP   = 3'd1,
    ET_ENC_CW   = 3'd2,
    ET_ENC_CCW  = 3'd3,
    ET_MOUSE    = 3'd4,
    ET_DELAY    = 3'd5
  } etype_t;

  typedef enum logic [1:0] {
    KIND_KEY_DOWN = 2'd0,
    KIND_KEY_UP   = 2'd1,
    KIND_MOUSE    = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_WR2  = 4'b0010,
    ST_RD   = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

  typedef struct packed {
    logic              emit_valid;
    logic [1:0]        emit_kind;
    logic [15:0]       emit_keycode;
    logic [7:0]        emit_modifiers;
    logic signed [7:0] emit_x;
    logic signed [7:0] emit_y;
    logic              rec_active;
    logic              is_playing;
    logic [8:0]        recorded_count;
  } res_t;

endpackage

FILE: design/terr_if.sv
// Valid/ready channel interfaces for input beats and result beats.
// No dependencies.
interface terr_in_if;
  logic              valid;
  logic              ready;
  logic [3:0]        action;
  logic [3:0]        slot;
  logic [15:0]       keycode;
  logic [7:0]        modifiers;
  logic [7:0]        knob_id;
  logic              clockwise;
  logic signed [7:0] move_x;
  logic signed [7:0] move_y;
  logic [31:0]       now_ms;

  modport source (output valid, action, slot, keycode, modifiers, knob_id, clockwise,
                  move_x, move_y, now_ms, input ready);
  modport sink   (input valid, action, slot, keycode, modifiers, knob_id, clockwise,
                  move_x, move_y, now_ms, output ready);
endinterface

interface terr_out_if;
  logic              valid;
  logic              ready;
  logic              emit_valid;
  logic [1:0]        emit_kind;
  logic [15:0]       emit_keycode;
  logic [7:0]        emit_modifiers;
  logic signed [7:0] emit_x;
  logic signed [7:0] emit_y;
  logic              rec_active;
  logic              is_playing;
  logic [8:0]        recorded_count;

  modport source (output valid, emit_valid, emit_kind, emit_keycode, emit_modifiers, emit_x,
                  emit_y, rec_active, is_playing, recorded_count, input ready);
  modport sink   (input valid, emit_valid, emit_kind, emit_keycode, emit_modifiers, emit_x,
                  emit_y, rec_active, is_playing, recorded_count, output ready);
endinterface

FILE: design/terr_ram.sv
// Generic simple dual-port RAM, one write and one registered read per cycle.
// No dependencies.
module terr_ram #(
  parameter int WIDTH = 35,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/terr_ctrl.sv
// Sequencer for record/replay: slot table, record and play pointers, output register.
// Depends on terr_pkg and terr_if; drives the event store RAM ports.
module terr_ctrl #(
  parameter int SLOT_COUNT = 4,
  parameter int ENTRIES_PER_SLOT = 256,
  localparam int DEPTH = SLOT_COUNT * ENTRIES_PER_SLOT,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                         clk,
  input  logic                         rst_n,
  terr_in_if.sink                      in_if,
  terr_out_if.source                   out_if,
  input  logic [15:0]                  mouse_min,
  output logic                         ram_we,
  output logic [AW-1:0]                ram_waddr,
  output logic [terr_pkg::ENTRY_W-1:0] ram_wdata,
  output logic [AW-1:0]                ram_raddr,
  input  logic [terr_pkg::ENTRY_W-1:0] ram_rdata
);
  import terr_pkg::*;

  localparam int CW = $clog2(ENTRIES_PER_SLOT + 1);
  localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [CW-1:0] EPS_C = CW'(ENTRIES_PER_SLOT);
  localparam logic [CW-1:0] EPS_LAST = CW'(ENTRIES_PER_SLOT - 1);

  state_t             state_r, state_nxt;
  logic               rec_on_r, rec_on_nxt;
  logic [SW-1:0]      rec_slot_r, rec_slot_nxt;
  logic [AW-1:0]      rec_base_r, rec_base_nxt;
  logic [CW-1:0]      rec_cnt_r, rec_cnt_nxt;
  logic [31:0]        rec_last_r, rec_last_nxt;
  logic               play_on_r, play_on_nxt;
  logic               fast_r, fast_nxt;
  logic [SW-1:0]      play_slot_r, play_slot_nxt;
  logic [AW-1:0]      play_base_r, play_base_nxt;
  logic [CW-1:0]      play_len_r, play_len_nxt;
  logic [CW-1:0]      play_idx_r, play_idx_nxt;
  logic               wait_r, wait_nxt;
  logic [31:0]        wake_r, wake_nxt;
  logic [31:0]        mouse_last_r, mouse_last_nxt;
  logic [31:0]        now_r, now_nxt;
  logic [ENTRY_W-1:0] wr2_r, wr2_nxt;
  logic               out_valid_r, out_valid_nxt;
  res_t               out_r, out_nxt;
  res_t               pend_r, pend_nxt;
  logic [CW-1:0]      tbl_cnt_r [SLOT_COUNT];
  logic               tbl_has_r [SLOT_COUNT];

  logic               tbl_we;
  logic               finish;
  logic               out_free;
  res_t               res;
  logic               slot_ok;
  logic [SW-1:0]      s_idx;
  logic [AW-1:0]      slot_base;
  logic               sel_has;
  logic [CW-1:0]      sel_cnt;
  logic [31:0]        wake_diff;
  logic               hold;
  logic               mouse_drop;
  logic [ENTRY_W-1:0] new_entry;
  logic [31:0]        rd_pay;
  logic [CW+8:0]      cnt_ext;

  assign in_if.ready = (state_r == ST_IDLE);
  assign ram_raddr   = play_base_r + AW'(play_idx_r);
  assign rd_pay      = ram_rdata[31:0];

  assign slot_ok   = {1'b0, in_if.slot} < 5'(SLOT_COUNT);
  assign s_idx     = in_if.slot[SW-1:0];
  assign slot_base = AW'(s_idx) * AW'(ENTRIES_PER_SLOT);
  // the slot being recorded reads as empty until recording stops
  assign sel_has   = tbl_has_r[s_idx] && !(rec_on_r && rec_slot_r == s_idx);
  assign sel_cnt   = tbl_cnt_r[s_idx];
  assign wake_diff = wake_r - in_if.now_ms;
  assign hold      = wait_r && (wake_diff != 32'd0) && !wake_diff[31];
  assign mouse_drop = (action_t'(in_if.action) == ACT_MOUSE) &&
                      ((in_if.now_ms - mouse_last_r) < {16'd0, mouse_min});

  always_comb begin
    case (action_t'(in_if.action))
      ACT_KEY_DOWN: new_entry = {ET_KEY_DOWN, 8'd0, in_if.modifiers, in_if.keycode};
      ACT_KEY_UP:   new_entry = {ET_KEY_UP, 8'd0, in_if.modifiers, in_if.keycode};
      ACT_ENCODER:  new_entry = {(in_if.clockwise ? ET_ENC_CW : ET_ENC_CCW), 24'd0,
                                 in_if.knob_id};
      default:      new_entry = {ET_MOUSE, 16'd0, in_if.move_y, in_if.move_x};
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    rec_on_nxt     = rec_on_r;
    rec_slot_nxt   = rec_slot_r;
    rec_base_nxt   = rec_base_r;
    rec_cnt_nxt    = rec_cnt_r;
    rec_last_nxt   = rec_last_r;
    play_on_nxt    = play_on_r;
    fast_nxt       = fast_r;
    play_slot_nxt  = play_slot_r;
    play_base_nxt  = play_base_r;
    play_len_nxt   = play_len_r;
    play_idx_nxt   = play_idx_r;
    wait_nxt       = wait_r;
    wake_nxt       = wake_r;
    mouse_last_nxt = mouse_last_r;
    now_nxt        = now_r;
    wr2_nxt        = wr2_r;
    out_valid_nxt  = out_valid_r;
    out_nxt        = out_r;
    pend_nxt       = pend_r;
    tbl_we         = 1'b0;
    finish         = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = rec_base_r + AW'(rec_cnt_r);
    ram_wdata      = wr2_r;
    res            = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_if.valid) begin
          finish  = 1'b1;
          now_nxt = in_if.now_ms;
          case (action_t'(in_if.action))
            ACT_TICK: begin
              if (play_on_r) begin
                if (play_idx_r >= play_len_r) begin
                  play_on_nxt  = 1'b0;
                  play_idx_nxt = '0;
                  wait_nxt     = 1'b0;
                end else if (!hold) begin
                  finish    = 1'b0;
                  state_nxt = ST_RD;
                end
              end
            end
            ACT_START_REC: begin
              if (slot_ok) begin
                tbl_we       = rec_on_r;
                play_on_nxt  = 1'b0;
                play_idx_nxt = '0;
                wait_nxt     = 1'b0;
                rec_on_nxt   = 1'b1;
                rec_slot_nxt = s_idx;
                rec_base_nxt = slot_base;
                rec_cnt_nxt  = '0;
                rec_last_nxt = in_if.now_ms;
              end
            end
            ACT_STOP_REC: begin
              if (rec_on_r) begin
                tbl_we     = 1'b1;
                rec_on_nxt = 1'b0;
              end
            end
            ACT_PLAY, ACT_PLAY_FAST: begin
              if (slot_ok && sel_has && sel_cnt != '0 &&
                  !(play_on_r && play_slot_r == s_idx)) begin
                tbl_we        = rec_on_r;
                rec_on_nxt    = 1'b0;
                play_on_nxt   = 1'b1;
                fast_nxt      = (action_t'(in_if.action) == ACT_PLAY_FAST);
                play_slot_nxt = s_idx;
                play_base_nxt = slot_base;
                play_len_nxt  = sel_cnt;
                play_idx_nxt  = '0;
                wait_nxt      = 1'b0;
              end
            end
            ACT_STOP_PLAY: begin
              play_on_nxt  = 1'b0;
              play_idx_nxt = '0;
              wait_nxt     = 1'b0;
            end
            ACT_KEY_DOWN, ACT_KEY_UP, ACT_ENCODER, ACT_MOUSE: begin
              if (rec_on_r && rec_cnt_r < EPS_C && !mouse_drop) begin
                if (action_t'(in_if.action) == ACT_MOUSE) begin
                  mouse_last_nxt = in_if.now_ms;
                end
                ram_we      = 1'b1;
                rec_cnt_nxt = rec_cnt_r + 1'b1;
                if (rec_cnt_r != '0) begin
                  ram_wdata = {ET_DELAY, in_if.now_ms - rec_last_r};
                  // event follows only if the delay did not fill the slot
                  if (rec_cnt_r != EPS_LAST) begin
                    finish    = 1'b0;
                    wr2_nxt   = new_entry;
                    state_nxt = ST_WR2;
                  end
                end else begin
                  ram_wdata    = new_entry;
                  rec_last_nxt = in_if.now_ms;
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_WR2: begin
        ram_we       = 1'b1;
        rec_cnt_nxt  = rec_cnt_r + 1'b1;
        rec_last_nxt = now_r;
        finish       = 1'b1;
      end
      ST_RD: begin
        finish       = 1'b1;
        wait_nxt     = 1'b0;
        play_idx_nxt = play_idx_r + 1'b1;
        case (etype_t'(ram_rdata[34:32]))
          ET_KEY_DOWN: begin
            res.emit_valid     = 1'b1;
            res.emit_kind      = KIND_KEY_DOWN;
            res.emit_keycode   = rd_pay[15:0];
            res.emit_modifiers = rd_pay[23:16];
          end
          ET_KEY_UP: begin
            res.emit_valid   = 1'b1;
            res.emit_kind    = KIND_KEY_UP;
            res.emit_keycode = rd_pay[15:0];
          end
          ET_MOUSE: begin
            res.emit_valid = 1'b1;
            res.emit_kind  = KIND_MOUSE;
            res.emit_x     = $signed(rd_pay[7:0]);
            res.emit_y     = $signed(rd_pay[15:8]);
          end
          ET_DELAY: begin
            if (!fast_r) begin
              wake_nxt = now_r + rd_pay;
              wait_nxt = 1'b1;
            end
          end
          default: ;
        endcase
      end
      ST_OUT: ;
      default: state_nxt = ST_IDLE;
    endcase

    cnt_ext            = {9'd0, rec_cnt_nxt};
    res.rec_active     = rec_on_nxt;
    res.is_playing     = play_on_nxt;
    res.recorded_count = rec_on_nxt ? cnt_ext[8:0] : 9'd0;

    out_free = !out_valid_r || out_if.ready;
    if (out_valid_r && out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (finish) begin
      if (out_free) begin
        out_valid_nxt = 1'b1;
        out_nxt       = res;
        state_nxt     = ST_IDLE;
      end else begin
        pend_nxt  = res;
        state_nxt = ST_OUT;
      end
    end
    if (state_r == ST_OUT && out_free) begin
      out_valid_nxt = 1'b1;
      out_nxt       = pend_r;
      state_nxt     = ST_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      rec_on_r     <= 1'b0;
      rec_slot_r   <= '0;
      rec_base_r   <= '0;
      rec_cnt_r    <= '0;
      rec_last_r   <= '0;
      play_on_r    <= 1'b0;
      fast_r       <= 1'b0;
      play_slot_r  <= '0;
      play_base_r  <= '0;
      play_len_r   <= '0;
      play_idx_r   <= '0;
      wait_r       <= 1'b0;
      wake_r       <= '0;
      mouse_last_r <= '0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        tbl_cnt_r[i] <= '0;
        tbl_has_r[i] <= 1'b0;
      end
    end else begin
      state_r      <= state_nxt;
      rec_on_r     <= rec_on_nxt;
      rec_slot_r   <= rec_slot_nxt;
      rec_base_r   <= rec_base_nxt;
      rec_cnt_r    <= rec_cnt_nxt;
      rec_last_r   <= rec_last_nxt;
      play_on_r    <= play_on_nxt;
      fast_r       <= fast_nxt;
      play_slot_r  <= play_slot_nxt;
      play_base_r  <= play_base_nxt;
      play_len_r   <= play_len_nxt;
      play_idx_r   <= play_idx_nxt;
      wait_r       <= wait_nxt;
      wake_r       <= wake_nxt;
      mouse_last_r <= mouse_last_nxt;
      out_valid_r  <= out_valid_nxt;
      if (tbl_we) begin
        tbl_cnt_r[rec_slot_r] <= rec_cnt_r;
        tbl_has_r[rec_slot_r] <= (rec_cnt_r != '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    now_r  <= now_nxt;
    wr2_r  <= wr2_nxt;
    out_r  <= out_nxt;
    pend_r <= pend_nxt;
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.emit_valid     = out_r.emit_valid;
  assign out_if.emit_kind      = out_r.emit_kind;
  assign out_if.emit_keycode   = out_r.emit_keycode;
  assign out_if.emit_modifiers = out_r.emit_modifiers;
  assign out_if.emit_x         = out_r.emit_x;
  assign out_if.emit_y         = out_r.emit_y;
  assign out_if.rec_active     = out_r.rec_active;
  assign out_if.is_playing     = out_r.is_playing;
  assign out_if.recorded_count = out_r.recorded_count;

  a_rec_play_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(rec_on_r && play_on_r))
    else $error("recording and playback active together");

  a_no_write_in_play: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> !play_on_r)
    else $error("event store written during playback");

  a_wr2_recording: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WR2) |-> (rec_on_r && rec_cnt_r < EPS_C))
    else $error("second write without room in the recording slot");

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    play_on_r |-> (play_idx_r <= play_len_r))
    else $error("play index beyond slot length");

endmodule

FILE: design/timed_event_record_replay.sv
// Timed event record/replay block. A beat that records an event writes the event entry alone
// for the first entry of a slot, and otherwise a delay entry then, if room is left, the event
// entry in ST_WR2, through the single write port of the event store. A tick that replays an
// entry reads the registered store output in ST_RD; other beats finish in ST_IDLE. A new
// beat is taken while the previous result still waits in the output register. The event store
// needs no clear. Depends on terr_pkg, terr_if, terr_ram and terr_ctrl.
module timed_event_record_replay #(
  parameter int SLOT_COUNT = 4,
  parameter int ENTRIES_PER_SLOT = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  terr_in_if.sink     in_if,
  terr_out_if.source  out_if,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);
  import terr_pkg::*;

  localparam int DEPTH = SLOT_COUNT * ENTRIES_PER_SLOT;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [15:0]        mouse_min_r;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mouse_min_r <= MOUSE_MIN_RST;
    end else if (cfg_we) begin
      mouse_min_r <= cfg_wdata;
    end
  end

  terr_ctrl #(
    .SLOT_COUNT       (SLOT_COUNT),
    .ENTRIES_PER_SLOT (ENTRIES_PER_SLOT)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .out_if    (out_if),
    .mouse_min (mouse_min_r),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  terr_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule
